### hdl/crq_pkg.sv
`timescale 1ns / 1ps

package crq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [2:0] ST_APPENDED = 3'd0;
    localparam logic [2:0] ST_MERGED   = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_DEQUEUED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [15:0] sound_id;
        logic [7:0]  volume;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_volume;
        logic [3:0]  pending_count;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       scan_step;
        logic       commit;
        logic [2:0] result;
    } cmd_t;

    typedef struct packed {
        logic is_deq;
        logic empty;
        logic full;
        logic hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

### hdl/crq_datapath.sv
`timescale 1ns / 1ps

module crq_datapath #(
    parameter int QUEUE_DEPTH = crq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  crq_pkg::req_t req,
    input  crq_pkg::cmd_t cmd,
    output crq_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output crq_pkg::rsp_t rsp
);
    import crq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  volume;
    } entry_t;

    entry_t           mem [QUEUE_DEPTH];
    logic [IDX_W-1:0] head_reg, head_next, tail_reg, tail_next, scan_reg, scan_next;
    logic [IDX_W-1:0] head_inc, tail_inc, scan_inc, rd_addr, wr_addr;
    req_t             item_reg;
    entry_t           rd_data_reg, wr_data;
    logic             mem_we;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg, rsp_next;
    logic [CNT_W-1:0] diff;
    logic [CNT_W+3:0] count_ext;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    always_comb
    begin
        head_inc = ring_next(head_reg);
        tail_inc = ring_next(tail_reg);
        scan_inc = ring_next(scan_reg);

        sts.is_deq   = (item_reg.mode == MODE_DEQ);
        sts.empty    = (head_reg == tail_reg);
        sts.full     = (tail_inc == head_reg);
        sts.hit      = (rd_data_reg.id == item_reg.sound_id);
        sts.last     = (scan_inc == tail_reg);
        sts.out_free = !rsp_valid_reg || rsp_ready;

        rd_addr   = cmd.scan_step ? scan_inc : head_reg;
        scan_next = rd_addr;

        head_next      = head_reg;
        tail_next      = tail_reg;
        mem_we         = 1'b0;
        wr_addr        = tail_reg;
        wr_data.id     = item_reg.sound_id;
        wr_data.volume = item_reg.volume;

        if (cmd.commit)
        begin
            case (cmd.result)
                ST_APPENDED:
                begin
                    mem_we    = 1'b1;
                    tail_next = tail_inc;
                end
                ST_MERGED:
                begin
                    if (item_reg.volume > rd_data_reg.volume)
                    begin
                        mem_we = 1'b1;
                    end
                    wr_addr    = scan_reg;
                    wr_data.id = rd_data_reg.id;
                end
                ST_DEQUEUED:
                begin
                    head_next = head_inc;
                end
                default:
                begin
                end
            endcase
        end

        diff = {1'b0, tail_next} - {1'b0, head_next};
        if (tail_next < head_next)
        begin
            diff = diff + CNT_W'(QUEUE_DEPTH);
        end
        count_ext = {4'b0000, diff};

        rsp_next.status        = cmd.result;
        rsp_next.out_id        = (cmd.result == ST_DEQUEUED) ? rd_data_reg.id : 16'd0;
        rsp_next.out_volume    = (cmd.result == ST_DEQUEUED) ? rd_data_reg.volume : 8'd0;
        rsp_next.pending_count = count_ext[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
        if (cmd.scan_start || cmd.scan_step)
        begin
            scan_reg    <= scan_next;
            rd_data_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("Result committed while the output beat is still held.");

    a_append_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (cmd.result == ST_APPENDED) |-> !sts.full)
        else $error("Append committed into a full ring.");

    a_dequeue_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (cmd.result == ST_DEQUEUED) |-> !sts.empty)
        else $error("Dequeue committed from an empty ring.");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg <= LAST_IDX) && (tail_reg <= LAST_IDX))
        else $error("Ring index out of range.");

endmodule

### hdl/crq_ctrl.sv
`timescale 1ns / 1ps

module crq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  crq_pkg::sts_t sts,
    output crq_pkg::cmd_t cmd
);
    import crq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] result_reg, result_next;

    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        cmd         = '0;
        cmd.result  = result_reg;
        req_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_COMMIT;
                if (sts.is_deq)
                begin
                    if (sts.empty)
                    begin
                        result_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        result_next    = ST_DEQUEUED;
                    end
                end
                else if (sts.full)
                begin
                    result_next = ST_DROPPED;
                end
                else if (sts.empty)
                begin
                    result_next = ST_APPENDED;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    result_next = ST_MERGED;
                    state_next  = S_COMMIT;
                end
                else if (sts.last)
                begin
                    result_next = ST_APPENDED;
                    state_next  = S_COMMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            result_reg <= ST_APPENDED;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    a_scan_live_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !sts.empty && !sts.full)
        else $error("Scan running on an empty or full ring.");

    a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) && !sts.out_free |=> (state_reg == S_COMMIT))
        else $error("Commit left while the output beat was still held.");

endmodule

### hdl/coalescing_request_ring_queue_core.sv
// Ring queue of pending sound requests that takes one beat at a time: an enqueue
// beat either appends, merges into a live entry with the same id (keeping the
// larger volume), or is dropped when QUEUE_DEPTH-1 entries are live; a dequeue
// beat pops the head entry or reports empty. An enqueue into a ring that is
// neither empty nor full scans the live entries from the head, reading the entry
// memory one entry per cycle, until it finds the same id or the last live entry.
// The result sits in an output register, so the next request beat is taken while
// a result still waits for rsp_ready.
`timescale 1ns / 1ps

module coalescing_request_ring_queue_core #(
    parameter int QUEUE_DEPTH = crq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  crq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output crq_pkg::rsp_t rsp
);
    import crq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    crq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    crq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### dv/crq_ring_checker.sv
`timescale 1ns / 1ps

module crq_ring_checker #(
    parameter int QUEUE_DEPTH = crq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  crq_pkg::req_t        req,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  crq_pkg::rsp_t        rsp,
    output int                   errors,
    output int                   waiting,
    output logic [4:0][31:0]     outcome_counts
);
    import crq_pkg::*;

    logic [15:0] slot_id [QUEUE_DEPTH];
    logic [7:0]  slot_volume [QUEUE_DEPTH];
    int          ring_head;
    int          ring_tail;
    rsp_t        outcome_q [$];
    int          mismatches;

    assign errors = mismatches;

    initial
    begin
        mismatches = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic rsp_t apply_request(input req_t r);
        rsp_t o;
        int   i;
        bit   hit;
        o = '0;
        if (r.mode == MODE_ENQ)
        begin
            if ((ring_tail + 1) % QUEUE_DEPTH == ring_head)
            begin
                o.status = ST_DROPPED;
            end
            else
            begin
                hit = 1'b0;
                i = ring_head;
                while (i != ring_tail && !hit)
                begin
                    if (slot_id[i] == r.sound_id)
                    begin
                        if (r.volume > slot_volume[i])
                        begin
                            slot_volume[i] = r.volume;
                        end
                        hit = 1'b1;
                    end
                    else
                    begin
                        i = (i + 1) % QUEUE_DEPTH;
                    end
                end
                if (hit)
                begin
                    o.status = ST_MERGED;
                end
                else
                begin
                    slot_id[ring_tail] = r.sound_id;
                    slot_volume[ring_tail] = r.volume;
                    ring_tail = (ring_tail + 1) % QUEUE_DEPTH;
                    o.status = ST_APPENDED;
                end
            end
        end
        else if (ring_head == ring_tail)
        begin
            o.status = ST_EMPTY;
        end
        else
        begin
            o.status = ST_DEQUEUED;
            o.out_id = slot_id[ring_head];
            o.out_volume = slot_volume[ring_head];
            ring_head = (ring_head + 1) % QUEUE_DEPTH;
        end
        o.pending_count = 4'((ring_tail + QUEUE_DEPTH - ring_head) % QUEUE_DEPTH);
        return o;
    endfunction

    // A response beat always belongs to a request beat taken at an earlier edge,
    // so it is matched before the request beat of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            ring_head = 0;
            ring_tail = 0;
            outcome_q.delete();
            waiting <= 0;
            outcome_counts <= '0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    report_mismatch($sformatf("response %h with no request outstanding", rsp));
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        report_mismatch($sformatf("status got %0d, want %0d",
                                                  rsp.status, want.status));
                    end
                    if (rsp.out_id !== want.out_id)
                    begin
                        report_mismatch($sformatf("out_id got %h, want %h",
                                                  rsp.out_id, want.out_id));
                    end
                    if (rsp.out_volume !== want.out_volume)
                    begin
                        report_mismatch($sformatf("out_volume got %h, want %h",
                                                  rsp.out_volume, want.out_volume));
                    end
                    if (rsp.pending_count !== want.pending_count)
                    begin
                        report_mismatch($sformatf("pending_count got %0d, want %0d",
                                                  rsp.pending_count, want.pending_count));
                    end
                end
                if (rsp.status <= ST_EMPTY)
                begin
                    outcome_counts[rsp.status] <= outcome_counts[rsp.status] + 1;
                end
            end
            if (req_valid && req_ready)
            begin
                outcome_q.push_back(apply_request(req));
            end
            waiting <= outcome_q.size();
        end
    end

endmodule

### dv/tb_coalescing_request_ring_queue_core.sv
`timescale 1ns / 1ps

module tb_coalescing_request_ring_queue_core;

    import crq_pkg::*;

    localparam int RANDOM_PER_PHASE = 509;
    localparam int ID_POOL_SIZE = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int               errors;
    int               results_waiting;
    logic [4:0][31:0] outcome_counts;

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          quiet_cycles;
    int          n_enqueue;
    int          n_dequeue;
    logic [15:0] id_pool [ID_POOL_SIZE];

    coalescing_request_ring_queue_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    crq_ring_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .errors         (errors),
        .waiting        (results_waiting),
        .outcome_counts (outcome_counts)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat accepted for %0d cycles.", quiet_cycles);
            $display("** coalescing_request_ring_queue_core: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic mode, input logic [15:0] id, input logic [7:0] vol);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= '{mode: mode, sound_id: id, volume: vol};
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        if (mode == MODE_ENQ)
        begin
            n_enqueue++;
        end
        else
        begin
            n_dequeue++;
        end
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (results_waiting != 0);
    endtask

    task automatic random_phase(input int count);
        int          burst_left;
        int          enq_pct;
        logic        mode;
        logic [15:0] id;
        logic [7:0]  vol;
        burst_left = 0;
        enq_pct = 50;
        for (int k = 0; k < ID_POOL_SIZE; k++)
        begin
            id_pool[k] = 16'($urandom);
        end
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 8);
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 50;
                    default: enq_pct = 15;
                endcase
            end
            burst_left--;
            mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
            case ($urandom_range(9))
                0:       id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                1, 2, 3: id = 16'($urandom);
                default: id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
            endcase
            case ($urandom_range(7))
                0:       vol = 8'h00;
                1:       vol = 8'hFF;
                default: vol = 8'($urandom);
            endcase
            send_request(mode, id, vol);
            if ($urandom_range(99) == 0)
            begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_ready <= 1'b0;
        quiet_cycles = 0;
        n_enqueue = 0;
        n_dequeue = 0;
        tx_idle_pct = 8;
        rx_idle_pct = 68;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(MODE_DEQ, 16'hFFFF, 8'hFF);
        send_request(MODE_ENQ, 16'h0000, 8'h00);
        send_request(MODE_ENQ, 16'hFFFF, 8'hFF);
        send_request(MODE_ENQ, 16'h0000, 8'h80);
        send_request(MODE_ENQ, 16'hFFFF, 8'h00);
        send_request(MODE_ENQ, 16'h0000, 8'h80);
        for (int k = 1; k <= 13; k++)
        begin
            send_request(MODE_ENQ, 16'h1111 * k, 8'(k * 19));
        end
        send_request(MODE_ENQ, 16'hABCD, 8'h55);
        send_request(MODE_ENQ, 16'h0000, 8'hFF);
        send_request(MODE_DEQ, 16'h0000, 8'h00);
        send_request(MODE_DEQ, 16'h5555, 8'hAA);
        send_request(MODE_ENQ, 16'h5A5A, 8'hA5);
        wait_for_results();

        random_phase(RANDOM_PER_PHASE);
        tx_idle_pct = 68;
        rx_idle_pct = 8;
        random_phase(RANDOM_PER_PHASE);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(RANDOM_PER_PHASE);

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d enqueue and %0d dequeue beats under three sender/receiver stall mixes.",
                 n_enqueue, n_dequeue);
        $display("Outcomes: appended %0d, merged %0d, dropped full %0d, dequeued %0d, empty %0d.",
                 outcome_counts[ST_APPENDED], outcome_counts[ST_MERGED],
                 outcome_counts[ST_DROPPED], outcome_counts[ST_DEQUEUED],
                 outcome_counts[ST_EMPTY]);
        if (errors == 0)
        begin
            $display("** coalescing_request_ring_queue_core: PASSED **");
        end
        else
        begin
            $display("** coalescing_request_ring_queue_core: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hdl/crq_pkg.sv
hdl/crq_datapath.sv
hdl/crq_ctrl.sv
hdl/coalescing_request_ring_queue_core.sv
dv/crq_ring_checker.sv
dv/tb_coalescing_request_ring_queue_core.sv
